/* rtl/gprq_pkg.sv */
// ----------------------------------------------------------------------------
// gprq_pkg
// Shared types, register indexes and constants of the gamepad press
// qualifier.
// ----------------------------------------------------------------------------
`default_nettype none

package gprq_pkg;

	// default sizes
	localparam int NUM_KEYS_DEF    = 24;
	localparam int COUNT_WIDTH_DEF = 16;

	// keys produced by the front end: 14 buttons, 2 triggers, 8 stick directions
	localparam int KEY_TOTAL   = 24;
	localparam int NUM_BUTTONS = 14;
	localparam int NUM_AXES    = 4;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_TRIG_ON    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRIG_OFF   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STICK_ONP  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STICK_ONN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STICK_OFFP = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STICK_OFFN = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY      = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 3'd7;

	// reset values of the registers
	localparam logic [7:0]         RST_TRIG_ON    = 8'd141;
	localparam logic [7:0]         RST_TRIG_OFF   = 8'd127;
	localparam logic [14:0]        RST_STICK_ONP  = 15'd18022;
	localparam logic signed [15:0] RST_STICK_ONN  = -16'sd18023;
	localparam logic [14:0]        RST_STICK_OFFP = 15'd16383;
	localparam logic signed [15:0] RST_STICK_OFFN = -16'sd16384;
	localparam logic [9:0]         RST_DELAY      = 10'd30;
	localparam logic [7:0]         RST_PERIOD     = 8'd6;

	// result fields
	localparam int KEY_IDX_W = 5;
	localparam int PRESS_W   = 14;
	localparam int PRESS_MAX = 16383;

	// button bit feeding each of the first 14 keys
	localparam logic [3:0] BUTTON_BIT [NUM_BUTTONS] =
		'{4'd12, 4'd13, 4'd14, 4'd15, 4'd9, 4'd8, 4'd0,
		  4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7};

	// register file contents
	typedef struct packed {
		logic [7:0]         trig_on;
		logic [7:0]         trig_off;
		logic [14:0]        stick_onp;
		logic signed [15:0] stick_onn;
		logic [14:0]        stick_offp;
		logic signed [15:0] stick_offn;
		logic [9:0]         delay;
		logic [7:0]         period;
	} cfg_t;

	// divider status
	typedef struct packed {
		logic done;
		logic rem_zero;
	} div_stat_t;

endpackage

`default_nettype wire

/* rtl/gprq_front.sv */
// ----------------------------------------------------------------------------
// gprq_front
// Accepts polls, runs trigger and stick hysteresis and pushes the pressed
// state of all keys into the key queue.
// ----------------------------------------------------------------------------
`default_nettype none

module gprq_front #(
	parameter int NUM_KEYS = gprq_pkg::NUM_KEYS_DEF
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  gprq_pkg::cfg_t           cfg,
	input  wire                      in_valid,
	output logic                     in_stall,
	input  wire                      sample_valid,
	input  wire  [15:0]              button_bits,
	input  wire  [7:0]               left_trigger_raw,
	input  wire  [7:0]               right_trigger_raw,
	input  wire  signed [15:0]       left_stick_x,
	input  wire  signed [15:0]       left_stick_y,
	input  wire  signed [15:0]       right_stick_x,
	input  wire  signed [15:0]       right_stick_y,
	input  wire                      queue_full,
	output logic                     push,
	output logic [NUM_KEYS-1:0]      pressed
);
	import gprq_pkg::*;

	localparam logic [1:0] DIR_CENTER = 2'd0;
	localparam logic [1:0] DIR_POS    = 2'd1;
	localparam logic [1:0] DIR_NEG    = 2'd2;

	logic [1:0]         trig_q;
	logic [1:0]         dir_q [NUM_AXES];
	logic [1:0]         trig_d;
	logic [1:0]         dir_d [NUM_AXES];
	logic signed [16:0] axis_raw [NUM_AXES];
	logic [15:0]        btn;
	logic [7:0]         lt;
	logic [7:0]         rt;
	logic [KEY_TOTAL-1:0] key_src;
	logic [31:0]        key_wide;

	// trigger latch: on test wins over off test
	function automatic logic trig_next(input logic cur, input logic [7:0] raw,
	                                   input cfg_t c);
		logic r;
		r = cur;
		if (raw >= c.trig_on)
			r = 1'b1;
		else if (raw <= c.trig_off)
			r = 1'b0;
		return r;
	endfunction

	// axis direction; Y axes swap the roles of the on thresholds
	function automatic logic [1:0] axis_next(input logic [1:0] cur,
	                                         input logic signed [16:0] raw,
	                                         input logic inv, input cfg_t c);
		logic signed [16:0] onp;
		logic signed [16:0] onn;
		logic signed [16:0] offp;
		logic signed [16:0] offn;
		logic               pos;
		logic               neg;
		logic [1:0]         r;
		onp  = signed'({2'b00, c.stick_onp});
		offp = signed'({2'b00, c.stick_offp});
		onn  = 17'(c.stick_onn);
		offn = 17'(c.stick_offn);
		pos  = inv ? (raw <= onn) : (raw >= onp);
		neg  = inv ? (raw >= onp) : (raw <= onn);
		r    = cur;
		if (pos)
			r = DIR_POS;
		else if (neg)
			r = DIR_NEG;
		else if (raw >= offn && raw <= offp)
			r = DIR_CENTER;
		return r;
	endfunction

	assign in_stall = queue_full;
	assign push     = in_valid && !queue_full;

	// a failed poll reads as all zero with cleared hysteresis state
	always_comb begin
		btn         = sample_valid ? button_bits : 16'd0;
		lt          = sample_valid ? left_trigger_raw : 8'd0;
		rt          = sample_valid ? right_trigger_raw : 8'd0;
		axis_raw[0] = sample_valid ? 17'(left_stick_x) : 17'sd0;
		axis_raw[1] = sample_valid ? 17'(left_stick_y) : 17'sd0;
		axis_raw[2] = sample_valid ? 17'(right_stick_x) : 17'sd0;
		axis_raw[3] = sample_valid ? 17'(right_stick_y) : 17'sd0;
		trig_d[0]   = trig_next(sample_valid && trig_q[0], lt, cfg);
		trig_d[1]   = trig_next(sample_valid && trig_q[1], rt, cfg);
		for (int a = 0; a < NUM_AXES; a++) begin
			dir_d[a] = axis_next(sample_valid ? dir_q[a] : DIR_CENTER, axis_raw[a],
			                     a[0], cfg);
		end
	end

	// key map
	always_comb begin
		key_src = '0;
		for (int k = 0; k < NUM_BUTTONS; k++) begin
			key_src[k] = btn[BUTTON_BIT[k]];
		end
		key_src[NUM_BUTTONS]     = trig_d[0];
		key_src[NUM_BUTTONS + 1] = trig_d[1];
		for (int a = 0; a < NUM_AXES; a++) begin
			key_src[NUM_BUTTONS + 2 + 2*a] = (dir_d[a] == DIR_POS);
			key_src[NUM_BUTTONS + 3 + 2*a] = (dir_d[a] == DIR_NEG);
		end
		key_wide = 32'(key_src);
		pressed  = key_wide[NUM_KEYS-1:0];
	end

	// hysteresis state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_q <= '0;
			for (int a = 0; a < NUM_AXES; a++) begin
				dir_q[a] <= DIR_CENTER;
			end
		end else if (push) begin
			trig_q <= trig_d;
			for (int a = 0; a < NUM_AXES; a++) begin
				dir_q[a] <= dir_d[a];
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/gprq_fifo.sv */
// ----------------------------------------------------------------------------
// gprq_fifo
// Two-entry queue of pressed-key vectors between front end and key scan.
// ----------------------------------------------------------------------------
`default_nettype none

module gprq_fifo #(
	parameter int WIDTH = gprq_pkg::NUM_KEYS_DEF
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  wire  [WIDTH-1:0] wdata,
	input  wire              pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);
	localparam int DEPTH = 2;
	localparam int AW    = $clog2(DEPTH);
	localparam int CNTW  = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [CNTW-1:0]  cnt_q;

	assign full  = (cnt_q == CNTW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wdata;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + AW'(1);
			if (pop)
				rd_q <= rd_q + AW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CNTW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CNTW'(1);
		end
	end

endmodule

`default_nettype wire

/* rtl/gprq_div.sv */
// ----------------------------------------------------------------------------
// gprq_div
// Bit-serial restoring divider, one quotient bit per cycle, for the repeat
// number and the repeat-phase test.
// ----------------------------------------------------------------------------
`default_nettype none

module gprq_div #(
	parameter int COUNT_WIDTH = gprq_pkg::COUNT_WIDTH_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	input  wire  [COUNT_WIDTH-1:0]      dividend,
	input  wire  [7:0]                  divisor,
	output logic [COUNT_WIDTH-1:0]      quot,
	output gprq_pkg::div_stat_t         stat
);
	import gprq_pkg::*;

	localparam int SW = $clog2(COUNT_WIDTH);

	logic                   busy_q;
	logic                   done_q;
	logic [SW-1:0]          step_q;
	logic [7:0]             rem_q;
	logic [COUNT_WIDTH-1:0] quo_q;
	logic [8:0]             trial;
	logic                   ge;
	logic [7:0]             rem_d;

	// one restoring step
	always_comb begin
		trial = {rem_q, quo_q[COUNT_WIDTH-1]};
		ge    = (trial >= {1'b0, divisor});
		rem_d = ge ? 8'(trial - {1'b0, divisor}) : trial[7:0];
	end

	assign quot          = quo_q;
	assign stat.done     = done_q;
	assign stat.rem_zero = (rem_q == 8'd0);

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= 8'd0;
		end else if (busy_q) begin
			quo_q <= {quo_q[COUNT_WIDTH-2:0], ge};
			rem_q <= rem_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + SW'(1);
			if (step_q == SW'(COUNT_WIDTH - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/gprq_back.sv */
// ----------------------------------------------------------------------------
// gprq_back
// Key scan: walks the keys of one queued poll in index order, updates the
// held counts and emits press, repeat and release items.
// ----------------------------------------------------------------------------
`default_nettype none

module gprq_back #(
	parameter int NUM_KEYS    = gprq_pkg::NUM_KEYS_DEF,
	parameter int COUNT_WIDTH = gprq_pkg::COUNT_WIDTH_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  gprq_pkg::cfg_t                   cfg,
	input  wire                              q_empty,
	input  wire  [NUM_KEYS-1:0]              q_data,
	output logic                             q_pop,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic [gprq_pkg::KEY_IDX_W-1:0]   key_index,
	output logic [gprq_pkg::PRESS_W-1:0]     press_value,
	output logic                             last_event
);
	import gprq_pkg::*;

	localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
	localparam int CW = COUNT_WIDTH;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DIV   = 2'd2;
	localparam logic [1:0] ST_FLUSH = 2'd3;

	logic [1:0]           state_q;
	logic [NUM_KEYS-1:0]  vec_q;
	logic [KW-1:0]        k_q;
	logic [CW-1:0]        count_q [NUM_KEYS];

	// last event found, held until the next one shows it is not the last
	logic                 pend_valid_q;
	logic [KEY_IDX_W-1:0] pend_key_q;
	logic [PRESS_W-1:0]   pend_val_q;

	logic                 out_valid_q;
	logic [KEY_IDX_W-1:0] out_key_q;
	logic [PRESS_W-1:0]   out_val_q;
	logic                 out_last_q;

	logic [CW-1:0]        cur;
	logic [CW-1:0]        cnt_inc;
	logic                 key_on;
	logic                 past_delay;
	logic [CW-1:0]        div_arg;
	logic [7:0]           period_eff;
	logic [CW-1:0]        quot;
	div_stat_t            dstat;
	logic [32:0]          quot_ext;
	logic [PRESS_W-1:0]   repeat_val;

	logic                 div_start;
	logic                 ev_now;
	logic [PRESS_W-1:0]   ev_val;
	logic                 key_done;
	logic                 cnt_wr;
	logic [CW-1:0]        cnt_new;
	logic                 out_free;
	logic                 blocked;
	logic                 advance;
	logic                 last_key;

	// current key
	always_comb begin
		cur        = count_q[k_q];
		cnt_inc    = cur + CW'(1);
		key_on     = vec_q[k_q];
		past_delay = (33'(cnt_inc) > 33'(cfg.delay));
		div_arg    = CW'(33'(cnt_inc) - 33'(cfg.delay));
		period_eff = (cfg.period == 8'd0) ? 8'd1 : cfg.period;
		quot_ext   = 33'(quot);
		repeat_val = (quot_ext >= 33'(PRESS_MAX)) ? PRESS_W'(PRESS_MAX)
		                                          : PRESS_W'(quot_ext + 33'd1);
		last_key   = (k_q == KW'(NUM_KEYS - 1));
	end

	// per-key decision
	always_comb begin
		div_start = 1'b0;
		ev_now    = 1'b0;
		ev_val    = '0;
		key_done  = 1'b0;
		cnt_wr    = 1'b0;
		cnt_new   = cnt_inc;
		case (state_q)
			ST_SCAN: begin
				if (key_on) begin
					if (&cur) begin
						key_done = 1'b1;
					end else if (cnt_inc == CW'(1)) begin
						ev_now   = 1'b1;
						ev_val   = PRESS_W'(1);
						cnt_wr   = 1'b1;
						key_done = 1'b1;
					end else if (past_delay) begin
						div_start = 1'b1;
					end else begin
						cnt_wr   = 1'b1;
						key_done = 1'b1;
					end
				end else begin
					key_done = 1'b1;
					if (cur != '0) begin
						ev_now  = 1'b1;
						cnt_wr  = 1'b1;
						cnt_new = '0;
					end
				end
			end
			ST_DIV: begin
				if (dstat.done) begin
					ev_now   = dstat.rem_zero;
					ev_val   = repeat_val;
					cnt_wr   = 1'b1;
					key_done = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_free = !out_valid_q || !out_stall;
	assign blocked  = ev_now && pend_valid_q && !out_free;
	assign advance  = key_done && !blocked;
	assign q_pop    = (state_q == ST_IDLE) && !q_empty;

	assign out_valid   = out_valid_q;
	assign key_index   = out_key_q;
	assign press_value = out_val_q;
	assign last_event  = out_last_q;

	// scan sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			k_q          <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						k_q     <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN, ST_DIV: begin
					if (div_start) begin
						state_q <= ST_DIV;
					end else if (advance) begin
						if (ev_now)
							pend_valid_q <= 1'b1;
						if (last_key) begin
							state_q <= ST_FLUSH;
						end else begin
							k_q     <= k_q + KW'(1);
							state_q <= ST_SCAN;
						end
					end
				end
				ST_FLUSH: begin
					if (!pend_valid_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// poll vector and pending item
	always_ff @(posedge clk) begin
		if (q_pop)
			vec_q <= q_data;
		if (advance && ev_now) begin
			pend_key_q <= KEY_IDX_W'(k_q);
			pend_val_q <= ev_val;
		end
	end

	// held counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_KEYS; k++) begin
				count_q[k] <= '0;
			end
		end else if (advance && cnt_wr) begin
			count_q[k_q] <= cnt_new;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((advance && ev_now && pend_valid_q) ||
		             (state_q == ST_FLUSH && pend_valid_q && out_free)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((advance && ev_now && pend_valid_q) ||
		    (state_q == ST_FLUSH && pend_valid_q && out_free)) begin
			out_key_q  <= pend_key_q;
			out_val_q  <= pend_val_q;
			out_last_q <= (state_q == ST_FLUSH);
		end
	end

	gprq_div #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_arg),
		.divisor (period_eff),
		.quot    (quot),
		.stat    (dstat)
	);

endmodule

`default_nettype wire

/* rtl/gamepad_press_repeat_qualifier_top.sv */
// ----------------------------------------------------------------------------
// gamepad_press_repeat_qualifier_top
// Gamepad poll to key press, auto-repeat and release items.
// ----------------------------------------------------------------------------
// Each accepted poll is classified at once by the front end (trigger and
// stick hysteresis) and queued as one pressed bit per key; the queue holds
// two polls. The key scan then visits the keys in index order, one key per
// cycle unless the output stalls or the divider runs, and a pressed key whose
// held count has passed the delay register also runs the bit-serial divider.
// The serial key scan and the divider set how long a poll takes. Results
// leave through an output register, one per cycle at best; last_event marks
// the last item of a poll, and a poll that changes nothing yields no item.
// Registers are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while the block is idle, as the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module gamepad_press_repeat_qualifier_top #(
	parameter int NUM_KEYS    = gprq_pkg::NUM_KEYS_DEF,
	parameter int COUNT_WIDTH = gprq_pkg::COUNT_WIDTH_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	// configuration
	input  wire                              cfg_we,
	input  wire  [gprq_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [gprq_pkg::CFG_DATA_W-1:0]  cfg_data,
	// poll channel
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire                              sample_valid,
	input  wire  [15:0]                      button_bits,
	input  wire  [7:0]                       left_trigger_raw,
	input  wire  [7:0]                       right_trigger_raw,
	input  wire  signed [15:0]               left_stick_x,
	input  wire  signed [15:0]               left_stick_y,
	input  wire  signed [15:0]               right_stick_x,
	input  wire  signed [15:0]               right_stick_y,
	// result channel
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic [gprq_pkg::KEY_IDX_W-1:0]   key_index,
	output logic [gprq_pkg::PRESS_W-1:0]     press_value,
	output logic                             last_event
);
	import gprq_pkg::*;

	cfg_t                cfg_q;
	logic                push;
	logic [NUM_KEYS-1:0] pressed;
	logic [NUM_KEYS-1:0] q_data;
	logic                q_full;
	logic                q_empty;
	logic                q_pop;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trig_on    <= RST_TRIG_ON;
			cfg_q.trig_off   <= RST_TRIG_OFF;
			cfg_q.stick_onp  <= RST_STICK_ONP;
			cfg_q.stick_onn  <= RST_STICK_ONN;
			cfg_q.stick_offp <= RST_STICK_OFFP;
			cfg_q.stick_offn <= RST_STICK_OFFN;
			cfg_q.delay      <= RST_DELAY;
			cfg_q.period     <= RST_PERIOD;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TRIG_ON:    cfg_q.trig_on    <= cfg_data[7:0];
				REG_TRIG_OFF:   cfg_q.trig_off   <= cfg_data[7:0];
				REG_STICK_ONP:  cfg_q.stick_onp  <= cfg_data[14:0];
				REG_STICK_ONN:  cfg_q.stick_onn  <= cfg_data;
				REG_STICK_OFFP: cfg_q.stick_offp <= cfg_data[14:0];
				REG_STICK_OFFN: cfg_q.stick_offn <= cfg_data;
				REG_DELAY:      cfg_q.delay      <= cfg_data[9:0];
				REG_PERIOD:     cfg_q.period     <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	gprq_front #(
		.NUM_KEYS(NUM_KEYS)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.sample_valid     (sample_valid),
		.button_bits      (button_bits),
		.left_trigger_raw (left_trigger_raw),
		.right_trigger_raw(right_trigger_raw),
		.left_stick_x     (left_stick_x),
		.left_stick_y     (left_stick_y),
		.right_stick_x    (right_stick_x),
		.right_stick_y    (right_stick_y),
		.queue_full       (q_full),
		.push             (push),
		.pressed          (pressed)
	);

	gprq_fifo #(
		.WIDTH(NUM_KEYS)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (pressed),
		.pop   (q_pop),
		.rdata (q_data),
		.full  (q_full),
		.empty (q_empty)
	);

	gprq_back #(
		.NUM_KEYS   (NUM_KEYS),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_empty    (q_empty),
		.q_data     (q_data),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.key_index  (key_index),
		.press_value(press_value),
		.last_event (last_event)
	);

endmodule

`default_nettype wire

/* rtl/gprq_checker.sv */
// ----------------------------------------------------------------------------
// gprq_checker
// Port-level checks of the gamepad press qualifier, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gprq_checker #(
	parameter int NUM_KEYS = gprq_pkg::NUM_KEYS_DEF
) (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              out_valid,
	input wire                              out_stall,
	input wire [gprq_pkg::KEY_IDX_W-1:0]    key_index,
	input wire [gprq_pkg::PRESS_W-1:0]      press_value,
	input wire                              last_event
);
	// a stalled item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(key_index) &&
		$stable(press_value) && $stable(last_event))
		else $error("stalled result item changed");

	// only existing keys are reported
	a_key_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(key_index) < NUM_KEYS))
		else $error("key index beyond key count");

	// within one poll, items come in rising key order
	a_key_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last_event) ##1 (out_valid && !out_stall)
		|-> (key_index > $past(key_index)))
		else $error("items of one poll out of key order");

endmodule

bind gamepad_press_repeat_qualifier_top gprq_checker #(
	.NUM_KEYS(NUM_KEYS)
) u_gprq_checker (.*);

`default_nettype wire

/* tb/tb_gamepad_press_repeat_qualifier_top.sv */
// ----------------------------------------------------------------------------
// tb_gamepad_press_repeat_qualifier_top
// Self-checking bench for the gamepad press qualifier. Polls go in through
// the valid/stall channel. A local predictor models trigger and stick
// hysteresis, held counts and repeat events. Every key item that leaves the
// block is compared with the oldest predicted item. The run starts with a
// directed stimulus list, goes on to random poll episodes over several
// register settings, and ends with a short hold of one button at the
// fastest repeat rate.
// ----------------------------------------------------------------------------

module tb_gamepad_press_repeat_qualifier_top;
	import gprq_pkg::*;

	localparam int KEYS    = NUM_KEYS_DEF;
	localparam int CNT_W   = COUNT_WIDTH_DEF;
	localparam int CNT_MAX = (1 << CNT_W) - 1;

	// worst poll: every key in its repeat range; the input queue holds two polls
	localparam int POLL_CYCLES_MAX = KEYS + 2 + KEYS * (CNT_W + 1);
	localparam int DRAIN_CYCLES    = 2 * POLL_CYCLES_MAX + 16;
	localparam int PRESSURE_CYCLES = 1500;
	// final hold: one repeat per poll after the first press
	localparam int HOLD_POLLS      = 16;
	// bound on the whole run; the worst case is every poll in the divider path with stalls
	localparam int CYCLE_LIMIT     = 1_000_000;

	localparam logic [1:0] DIR_CENTER = 2'd0;
	localparam logic [1:0] DIR_POS    = 2'd1;
	localparam logic [1:0] DIR_NEG    = 2'd2;

	localparam logic [4:0] KEY_A        = 5'd0;
	localparam logic [4:0] KEY_LT       = 5'd14;
	localparam logic [4:0] KEY_RT       = 5'd15;
	localparam logic [4:0] KEY_LS_RIGHT = 5'd16;
	localparam logic [4:0] KEY_LS_LEFT  = 5'd17;
	localparam logic [4:0] KEY_LS_UP    = 5'd19;
	localparam logic [4:0] KEY_RS_DOWN  = 5'd22;
	localparam logic [15:0] BTN_A       = 16'h1000;

	typedef struct packed {
		logic               sv;
		logic [15:0]        btn;
		logic [7:0]         lt;
		logic [7:0]         rt;
		logic signed [15:0] lx;
		logic signed [15:0] ly;
		logic signed [15:0] rx;
		logic signed [15:0] ry;
	} poll_t;

	typedef struct packed {
		logic [KEY_IDX_W-1:0] key;
		logic [PRESS_W-1:0]   press;
		logic                 last;
	} key_event_t;

	// chk set: the row yields exactly one item, typed in beside it
	typedef struct packed {
		poll_t                p;
		logic                 chk;
		logic [KEY_IDX_W-1:0] key;
		logic [PRESS_W-1:0]   press;
	} dir_row_t;

	localparam int DIR_N = 23;
	localparam dir_row_t DIR_ROWS [DIR_N] = '{
		// single button: first press, then release
		'{'{1'b1, BTN_A, 8'd0, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, KEY_A, 14'd1},
		'{'{1'b1, 16'h0000, 8'd0, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, KEY_A, 14'd0},
		// all buttons, then a failed poll carrying junk
		'{'{1'b1, 16'hFFFF, 8'd0, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, 5'd0, 14'd0},
		'{'{1'b0, 16'hFFFF, 8'd255, 8'd255, 16'sd32767, -16'sd32768, 16'sd32767,
			-16'sd32768}, 1'b0, 5'd0, 14'd0},
		// left trigger at the exact on level, in between, at the exact off level
		'{'{1'b1, 16'h0000, 8'd141, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, KEY_LT, 14'd1},
		'{'{1'b1, 16'h0000, 8'd140, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, 5'd0, 14'd0},
		'{'{1'b1, 16'h0000, 8'd127, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, KEY_LT, 14'd0},
		// right trigger at full scale, in between, at zero
		'{'{1'b1, 16'h0000, 8'd0, 8'd255, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, KEY_RT, 14'd1},
		'{'{1'b1, 16'h0000, 8'd0, 8'd128, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, 5'd0, 14'd0},
		'{'{1'b1, 16'h0000, 8'd0, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, KEY_RT, 14'd0},
		// left stick x: positive side on, hold, clear at the band edge
		'{'{1'b1, 16'h0000, 8'd0, 8'd0, 16'sd18022, 16'sd0, 16'sd0, 16'sd0},
			1'b1, KEY_LS_RIGHT, 14'd1},
		'{'{1'b1, 16'h0000, 8'd0, 8'd0, 16'sd17000, 16'sd0, 16'sd0, 16'sd0}, 1'b0, 5'd0, 14'd0},
		'{'{1'b1, 16'h0000, 8'd0, 8'd0, 16'sd16383, 16'sd0, 16'sd0, 16'sd0},
			1'b1, KEY_LS_RIGHT, 14'd0},
		// negative side on, full scale, clear at the band edge
		'{'{1'b1, 16'h0000, 8'd0, 8'd0, -16'sd18023, 16'sd0, 16'sd0, 16'sd0},
			1'b1, KEY_LS_LEFT, 14'd1},
		'{'{1'b1, 16'h0000, 8'd0, 8'd0, -16'sd32768, 16'sd0, 16'sd0, 16'sd0}, 1'b0, 5'd0, 14'd0},
		'{'{1'b1, 16'h0000, 8'd0, 8'd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd0},
			1'b1, KEY_LS_LEFT, 14'd0},
		// y is inverted: raw up is up, raw down is down
		'{'{1'b1, 16'h0000, 8'd0, 8'd0, 16'sd0, 16'sd32767, 16'sd0, 16'sd0},
			1'b1, KEY_LS_UP, 14'd1},
		'{'{1'b1, 16'h0000, 8'd0, 8'd0, 16'sd0, 16'sd32767, 16'sd0, -16'sd32768},
			1'b1, KEY_RS_DOWN, 14'd1},
		// failed poll releases held stick keys
		'{'{1'b0, 16'h5A5A, 8'd200, 8'd200, 16'sd20000, 16'sd20000, -16'sd20000,
			-16'sd20000}, 1'b0, 5'd0, 14'd0},
		// everything at its extreme
		'{'{1'b1, 16'hFFFF, 8'd255, 8'd255, 16'sd32767, -16'sd32768, -16'sd32768,
			16'sd32767}, 1'b0, 5'd0, 14'd0},
		// only the unused button bits
		'{'{1'b1, 16'h0C00, 8'd0, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, 5'd0, 14'd0},
		'{'{1'b1, 16'h0000, 8'd0, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, 5'd0, 14'd0},
		'{'{1'b0, 16'h0000, 8'd0, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, 5'd0, 14'd0}
	};

	// DUT ports
	logic                  clk;
	logic                  arst_n            = 1'b0;
	logic                  cfg_we            = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index         = '0;
	logic [CFG_DATA_W-1:0] cfg_data          = '0;
	logic                  in_valid          = 1'b0;
	logic                  in_stall;
	logic                  sample_valid      = 1'b0;
	logic [15:0]           button_bits       = '0;
	logic [7:0]            left_trigger_raw  = '0;
	logic [7:0]            right_trigger_raw = '0;
	logic signed [15:0]    left_stick_x      = '0;
	logic signed [15:0]    left_stick_y      = '0;
	logic signed [15:0]    right_stick_x     = '0;
	logic signed [15:0]    right_stick_y     = '0;
	logic                  out_valid;
	logic                  out_stall         = 1'b0;
	logic [KEY_IDX_W-1:0]  key_index;
	logic [PRESS_W-1:0]    press_value;
	logic                  last_event;

	// predictor state and register mirror
	cfg_t       regs;
	int         held_cnt [KEYS];
	logic       trig_latched [2];
	logic [1:0] stick_dir [4];
	key_event_t key_events_due [$];

	// run control
	bit idle_allowed = 1'b1;
	bit idle_en      = 1'b1;
	bit pressure_go  = 1'b0;
	int errors       = 0;
	int polls_sent   = 0;
	int results_seen = 0;
	int repeats_seen = 0;
	int ceiling_seen = 0;
	int cfg_phases   = 0;
	int cycle_count  = 0;

	// random episode state
	int          ep_left;
	logic [15:0] ep_btn;
	int          ep_lt;
	int          ep_rt;
	int          ep_ax [4];

	gamepad_press_repeat_qualifier_top #(
		.NUM_KEYS   (KEYS),
		.COUNT_WIDTH(CNT_W)
	) u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.sample_valid     (sample_valid),
		.button_bits      (button_bits),
		.left_trigger_raw (left_trigger_raw),
		.right_trigger_raw(right_trigger_raw),
		.left_stick_x     (left_stick_x),
		.left_stick_y     (left_stick_y),
		.right_stick_x    (right_stick_x),
		.right_stick_y    (right_stick_y),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.key_index        (key_index),
		.press_value      (press_value),
		.last_event       (last_event)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// predictor reset
	initial begin
		regs.trig_on    = RST_TRIG_ON;
		regs.trig_off   = RST_TRIG_OFF;
		regs.stick_onp  = RST_STICK_ONP;
		regs.stick_onn  = RST_STICK_ONN;
		regs.stick_offp = RST_STICK_OFFP;
		regs.stick_offn = RST_STICK_OFFN;
		regs.delay      = RST_DELAY;
		regs.period     = RST_PERIOD;
		for (int k = 0; k < KEYS; k++) held_cnt[k] = 0;
		for (int t = 0; t < 2; t++) trig_latched[t] = 1'b0;
		for (int a = 0; a < 4; a++) stick_dir[a] = DIR_CENTER;
	end

	function automatic int clamp_int(input int v, input int lo, input int hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// symmetric jitter of +-j
	function automatic int jitter(input int j);
		return int'($urandom_range(0, 2 * j)) - j;
	endfunction

	// Poll to key items: hysteresis, held counts, repeat arithmetic.
	// Returns the number of items queued.
	function automatic int qualify_poll(input poll_t p);
		logic [15:0] btn;
		int          trig [2];
		int          ax [4];
		logic        pressed [KEYS];
		int          on_lvl, off_lvl, onp, onn, offp, offn, dly, per;
		int          c, val, n, d;
		logic        pos, neg, emit;
		key_event_t  ev;
		n       = 0;
		btn     = p.sv ? p.btn : 16'h0000;
		trig[0] = p.sv ? int'(p.lt) : 0;
		trig[1] = p.sv ? int'(p.rt) : 0;
		ax[0]   = p.sv ? int'($signed(p.lx)) : 0;
		ax[1]   = p.sv ? int'($signed(p.ly)) : 0;
		ax[2]   = p.sv ? int'($signed(p.rx)) : 0;
		ax[3]   = p.sv ? int'($signed(p.ry)) : 0;
		on_lvl  = int'(regs.trig_on);
		off_lvl = int'(regs.trig_off);
		onp     = int'(regs.stick_onp);
		onn     = int'($signed(regs.stick_onn));
		offp    = int'(regs.stick_offp);
		offn    = int'($signed(regs.stick_offn));
		dly     = int'(regs.delay);
		per     = (regs.period == 8'd0) ? 1 : int'(regs.period);

		// failed poll drops latches and directions before the hysteresis runs
		if (!p.sv) begin
			for (int t = 0; t < 2; t++) trig_latched[t] = 1'b0;
			for (int a = 0; a < 4; a++) stick_dir[a] = DIR_CENTER;
		end

		// trigger hysteresis, on test first
		for (int t = 0; t < 2; t++) begin
			if (trig[t] >= on_lvl)
				trig_latched[t] = 1'b1;
			else if (trig[t] <= off_lvl)
				trig_latched[t] = 1'b0;
		end

		// axis hysteresis; odd axes are y and swap the on tests
		for (int a = 0; a < 4; a++) begin
			d   = ax[a];
			pos = (a % 2 == 1) ? (d <= onn) : (d >= onp);
			neg = (a % 2 == 1) ? (d >= onp) : (d <= onn);
			if (pos)
				stick_dir[a] = DIR_POS;
			else if (neg)
				stick_dir[a] = DIR_NEG;
			else if (d >= offn && d <= offp)
				stick_dir[a] = DIR_CENTER;
		end

		for (int k = 0; k < NUM_BUTTONS; k++) pressed[k] = btn[BUTTON_BIT[k]];
		pressed[14] = trig_latched[0];
		pressed[15] = trig_latched[1];
		for (int a = 0; a < NUM_AXES; a++) begin
			pressed[16 + 2 * a] = (stick_dir[a] == DIR_POS);
			pressed[17 + 2 * a] = (stick_dir[a] == DIR_NEG);
		end

		// key scan in index order
		for (int k = 0; k < KEYS; k++) begin
			emit = 1'b0;
			val  = 0;
			if (pressed[k]) begin
				c = held_cnt[k];
				if (c < CNT_MAX) begin
					c++;
					held_cnt[k] = c;
					if (c == 1) begin
						emit = 1'b1;
						val  = 1;
					end else if (c > dly && (c - dly) % per == 0) begin
						emit = 1'b1;
						val  = clamp_int((c - dly) / per + 1, 0, PRESS_MAX);
					end
				end
			end else if (held_cnt[k] != 0) begin
				held_cnt[k] = 0;
				emit        = 1'b1;
			end
			if (emit) begin
				ev.key   = k[KEY_IDX_W-1:0];
				ev.press = val[PRESS_W-1:0];
				ev.last  = 1'b0;
				key_events_due.push_back(ev);
				n++;
			end
		end
		if (n > 0) begin
			ev      = key_events_due.pop_back();
			ev.last = 1'b1;
			key_events_due.push_back(ev);
		end
		return n;
	endfunction

	// offer one poll, with an optional leading gap, until it is accepted
	task automatic send_poll(input poll_t p, output int n);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid          <= 1'b1;
		sample_valid      <= p.sv;
		button_bits       <= p.btn;
		left_trigger_raw  <= p.lt;
		right_trigger_raw <= p.rt;
		left_stick_x      <= p.lx;
		left_stick_y      <= p.ly;
		right_stick_x     <= p.rx;
		right_stick_y     <= p.ry;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		n = qualify_poll(p);
		polls_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
	endtask

	// write the whole register file; unused upper data bits carry noise
	task automatic apply_cfg(input cfg_t c);
		write_reg(REG_TRIG_ON, {8'($urandom), c.trig_on});
		write_reg(REG_TRIG_OFF, {8'($urandom), c.trig_off});
		write_reg(REG_STICK_ONP, {1'($urandom), c.stick_onp});
		write_reg(REG_STICK_ONN, c.stick_onn);
		write_reg(REG_STICK_OFFP, {1'($urandom), c.stick_offp});
		write_reg(REG_STICK_OFFN, c.stick_offn);
		write_reg(REG_DELAY, {6'($urandom), c.delay});
		write_reg(REG_PERIOD, {8'($urandom), c.period});
		cfg_we <= 1'b0;
		regs = c;
		cfg_phases++;
	endtask

	// all items out, then enough cycles for polls that yield nothing
	task automatic wait_drained();
		while (key_events_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic int pick_trig();
		case ($urandom_range(0, 4))
			0:       return int'($urandom_range(0, 255));
			1:       return clamp_int(int'(regs.trig_on) + jitter(2), 0, 255);
			2:       return clamp_int(int'(regs.trig_off) + jitter(2), 0, 255);
			3:       return 0;
			default: return 255;
		endcase
	endfunction

	function automatic int pick_axis();
		logic [15:0] r;
		int          v;
		r = 16'($urandom);
		case ($urandom_range(0, 6))
			0:       v = int'($signed(r));
			1:       v = int'(regs.stick_onp) + jitter(2);
			2:       v = int'($signed(regs.stick_onn)) + jitter(2);
			3:       v = int'(regs.stick_offp) + jitter(2);
			4:       v = int'($signed(regs.stick_offn)) + jitter(2);
			5:       v = 0;
			default: v = r[0] ? 32767 : -32768;
		endcase
		return clamp_int(v, -32768, 32767);
	endfunction

	// Mostly held episodes with small jitter, some failed polls and
	// flipped buttons, and a tenth of pure noise.
	task automatic next_random_poll(input int max_run, output poll_t p);
		int r, j;
		if (ep_left == 0) begin
			ep_left = $urandom_range(1, max_run);
			ep_btn  = 16'($urandom & $urandom);
			ep_lt   = pick_trig();
			ep_rt   = pick_trig();
			for (int a = 0; a < 4; a++) ep_ax[a] = pick_axis();
			idle_en = idle_allowed && ($urandom_range(0, 3) != 0);
		end
		ep_left--;
		r = $urandom_range(0, 99);
		j = (r % 3 == 0) ? 3 : 0;
		if (r < 10) begin
			p.sv  = 1'($urandom);
			p.btn = 16'($urandom);
			p.lt  = 8'($urandom);
			p.rt  = 8'($urandom);
			p.lx  = 16'($urandom);
			p.ly  = 16'($urandom);
			p.rx  = 16'($urandom);
			p.ry  = 16'($urandom);
		end else begin
			p.sv  = ($urandom_range(0, 24) != 0);
			p.btn = ep_btn;
			if (r < 20) p.btn = p.btn ^ (16'h0001 << $urandom_range(0, 15));
			p.lt  = 8'(clamp_int(ep_lt + jitter(j), 0, 255));
			p.rt  = 8'(clamp_int(ep_rt + jitter(j), 0, 255));
			p.lx  = 16'(clamp_int(ep_ax[0] + jitter(j), -32768, 32767));
			p.ly  = 16'(clamp_int(ep_ax[1] + jitter(j), -32768, 32767));
			p.rx  = 16'(clamp_int(ep_ax[2] + jitter(j), -32768, 32767));
			p.ry  = 16'(clamp_int(ep_ax[3] + jitter(j), -32768, 32767));
		end
	endtask

	task automatic run_random(input int count, input int max_run);
		poll_t p;
		int    n;
		ep_left = 0;
		for (int i = 0; i < count; i++) begin
			next_random_poll(max_run, p);
			send_poll(p, n);
		end
		in_valid <= 1'b0;
		wait_drained();
	endtask

	task automatic report_field(input string name, input int exp_v, input int act_v);
		errors++;
		$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
	endtask

	// result side: checks each accepted item, drives stall bursts
	initial begin : sink
		key_event_t ev;
		int         stall_left;
		bit         pressure_done;
		stall_left    = 0;
		pressure_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (key_events_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected item: expected none, actual key %0d press %0d",
						$time, key_index, press_value);
				end else begin
					ev = key_events_due.pop_front();
					if (key_index !== ev.key)
						report_field("key_index", int'(ev.key), int'(key_index));
					if (press_value !== ev.press)
						report_field("press_value", int'(ev.press), int'(press_value));
					if (last_event !== ev.last)
						report_field("last_event", int'(ev.last), int'(last_event));
					results_seen++;
					if (ev.press > 1) repeats_seen++;
					if (ev.press == PRESS_W'(PRESS_MAX)) ceiling_seen++;
				end
			end
			// one long hold-off so the input side backs up
			if (pressure_go && !pressure_done) begin
				pressure_done = 1'b1;
				stall_left    = PRESSURE_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (idle_en && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 9) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles, %0d items still due", cycle_count,
			key_events_due.size());
		$display("Simulation FAILED");
		$finish;
	end

	initial begin : stimulus
		dir_row_t   row;
		key_event_t ev;
		cfg_t       c;
		poll_t      p;
		int         n;
		int         onn_mag;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed list at reset settings
		for (int i = 0; i < DIR_N; i++) begin
			row = DIR_ROWS[i];
			send_poll(row.p, n);
			if (row.chk) begin
				if (n != 1 || key_events_due.size() == 0) begin
					errors++;
					$display("%0t: directed row %0d: expected 1 item, predicted %0d",
						$time, i, n);
				end else begin
					ev = key_events_due[key_events_due.size() - 1];
					if (ev.key != row.key || ev.press != row.press || !ev.last) begin
						errors++;
						$display("%0t: directed row %0d: expected key %0d press %0d, got %0d %0d",
							$time, i, row.key, row.press, ev.key, ev.press);
					end
				end
			end
		end
		in_valid <= 1'b0;
		wait_drained();

		// reset settings, long episodes to reach repeats, with back-pressure
		pressure_go = 1'b1;
		run_random(40, 45);

		// extremes: triggers always latched, stick on tests at zero
		c.trig_on    = 8'd0;
		c.trig_off   = 8'd255;
		c.stick_onp  = 15'd0;
		c.stick_onn  = 16'sd0;
		c.stick_offp = 15'd32767;
		c.stick_offn = -16'sd32768;
		c.delay      = 10'd1;
		c.period     = 8'd1;
		apply_cfg(c);
		run_random(20, 10);

		// opposite extremes: narrow on tests, a band of zero alone, slowest repeats
		c.trig_on    = 8'd255;
		c.trig_off   = 8'd0;
		c.stick_onp  = 15'd32767;
		c.stick_onn  = -16'sd32768;
		c.stick_offp = 15'd0;
		c.stick_offn = 16'sd0;
		c.delay      = 10'd1023;
		c.period     = 8'd255;
		apply_cfg(c);
		run_random(20, 10);

		// random settings with short delays; period zero comes up often
		for (int ph = 0; ph < 3; ph++) begin
			c.trig_on    = 8'($urandom);
			c.trig_off   = 8'($urandom);
			c.stick_onp  = 15'($urandom);
			onn_mag      = $urandom_range(0, 32768);
			c.stick_onn  = 16'(-onn_mag);
			c.stick_offp = 15'($urandom);
			onn_mag      = $urandom_range(0, 32768);
			c.stick_offn = 16'(-onn_mag);
			c.delay      = 10'($urandom_range(1, 8));
			c.period     = 8'($urandom_range(0, 4));
			apply_cfg(c);
			if (ph == 2) begin
				idle_allowed = 1'b0;
				idle_en      = 1'b0;
			end
			run_random(17, 12);
		end

		// hold of one button, zero delay and zero period, no idling:
		// a repeat on every poll after the first press
		c.trig_on    = RST_TRIG_ON;
		c.trig_off   = RST_TRIG_OFF;
		c.stick_onp  = RST_STICK_ONP;
		c.stick_onn  = RST_STICK_ONN;
		c.stick_offp = RST_STICK_OFFP;
		c.stick_offn = RST_STICK_OFFN;
		c.delay      = 10'd0;
		c.period     = 8'd0;
		apply_cfg(c);
		p = '0;
		p.sv = 1'b1;
		for (int i = 0; i < HOLD_POLLS; i++) begin
			p.btn = (i == 0) ? 16'h0000 : BTN_A;
			send_poll(p, n);
		end
		in_valid <= 1'b0;
		wait_drained();

		$display("Covered %0d polls and %0d key items (%0d repeats, %0d at the ceiling)",
			polls_sent, results_seen, repeats_seen, ceiling_seen);
		$display("over %0d register settings, failed polls, stalls and a long hold-off",
			cfg_phases + 1);
		if (errors == 0 && key_events_due.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

/* files.f */
rtl/gprq_pkg.sv
rtl/gprq_front.sv
rtl/gprq_fifo.sv
rtl/gprq_div.sv
rtl/gprq_back.sv
rtl/gamepad_press_repeat_qualifier_top.sv
rtl/gprq_checker.sv
tb/tb_gamepad_press_repeat_qualifier_top.sv
